@@ src/gamepad_packet_to_input_events_macros.svh @@
// Assertion macros shared by the block's modules
`ifndef GAMEPAD_PACKET_TO_INPUT_EVENTS_MACROS_SVH
`define GAMEPAD_PACKET_TO_INPUT_EVENTS_MACROS_SVH

// Assert that an antecedent implies a consequent in the same cycle
`define GP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert that an antecedent implies a consequent in the following cycle
`define GP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/gpe_pkg.sv @@
package gpe_pkg;

  localparam int unsigned QueueDepth = 2;

  // Register indexes
  localparam logic [2:0] REG_LX  = 3'd0;
  localparam logic [2:0] REG_LY  = 3'd1;
  localparam logic [2:0] REG_RX  = 3'd2;
  localparam logic [2:0] REG_RY  = 3'd3;
  localparam logic [2:0] REG_LDZ = 3'd4;
  localparam logic [2:0] REG_RDZ = 3'd5;
  localparam logic [2:0] REG_FDZ = 3'd6;

  localparam logic [47:0] CAL_RESET = 48'h8000_FFFF_0000;

  // One classified packet handed from front to back
  typedef struct packed {
    logic        side;
    logic [15:0] x_raw;
    logic [15:0] y_raw;
    logic [7:0]  button_bits;
  } pkt_t;

  // Button target for the right byte, bit order 0..7
  function automatic logic [4:0] right_target(input logic [2:0] b);
    logic [4:0] t;
    begin
      case (b)
        3'd0: t = 5'd11;
        3'd1: t = 5'd13;
        3'd2: t = 5'd8;
        3'd3: t = 5'd9;
        3'd4: t = 5'd7;
        3'd5: t = 5'd6;
        3'd6: t = 5'd14;
        default: t = 5'd15;
      endcase
      return t;
    end
  endfunction

  // Right byte bit checked at event slot k: south, east, north, west,
  // tr, tr2, select, start
  function automatic logic [2:0] right_bit(input logic [2:0] k);
    logic [2:0] b;
    begin
      case (k)
        3'd0: b = 3'd4;
        3'd1: b = 3'd5;
        3'd2: b = 3'd2;
        3'd3: b = 3'd3;
        3'd4: b = 3'd0;
        3'd5: b = 3'd1;
        3'd6: b = 3'd6;
        default: b = 3'd7;
      endcase
      return b;
    end
  endfunction

endpackage

@@ src/gamepad_packet_to_input_events.sv @@
// Channel | Ports          | Word layout (low bit first)
// in      | in_t*          | tdata: x_raw[16], y_raw[16], button_bits[8]; tuser: side
// out     | out_t*         | tdata: target[5], value[16]; tlast: last
// cfg     | cfg_we/idx/dat | register index 0..6, 48-bit data
// Each packet, once the idle state pulls it from the queue, runs per axis through
// a setup state, a 34-step divide and a finish state, then one collect state;
// events follow one per cycle while out_tready is high (up to 10).
// A two-word input queue keeps taking packets while events drain.
// Reset (rst_n low, synchronous) restores calibration and clears history.
module gamepad_packet_to_input_events
  import gpe_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // x_raw, y_raw, button_bits
  input  logic        in_tuser,   // side
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // target, value, zero fill
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  pkt_t in_pkt, q_pkt;
  logic q_valid, q_ready;
  logic [4:0]  ev_target;
  logic [15:0] ev_value;

  assign in_pkt = '{side: in_tuser, x_raw: in_tdata[15:0], y_raw: in_tdata[31:16],
                    button_bits: in_tdata[39:32]};

  gpe_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready), .in_pkt,
    .q_valid, .q_ready, .q_pkt
  );

  gpe_back u_back (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data, .q_valid, .q_ready, .q_pkt,
    .ev_valid(out_tvalid), .ev_ready(out_tready), .ev_target, .ev_value,
    .ev_last(out_tlast)
  );

  assign out_tdata = {3'b000, ev_value, ev_target};
endmodule

@@ src/gpe_front.sv @@
module gpe_front
  import gpe_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  pkt_t in_pkt,
  output logic q_valid,
  input  logic q_ready,
  output pkt_t q_pkt
);
  `include "gamepad_packet_to_input_events_macros.svh"

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  pkt_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;
  logic push, pop;

  assign in_ready = (cnt_r != (AW+1)'(DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign q_pkt    = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  // Store incoming words
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= in_pkt;
  end

  // Advance pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (pop)  rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  `GP_ASSERT_IMP(a_cnt_max, 1'b1, cnt_r <= (AW+1)'(DEPTH), "queue overfilled")
  `GP_ASSERT_NEXT(a_push_cnt, push && !pop, cnt_r == $past(cnt_r) + 1'b1, "count slip")
  `GP_ASSERT_NEXT(a_pop_cnt, pop && !push, cnt_r == $past(cnt_r) - 1'b1, "count slip")
endmodule

@@ src/gpe_back.sv @@
module gpe_back
  import gpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  input  logic        q_valid,
  output logic        q_ready,
  input  pkt_t        q_pkt,
  output logic        ev_valid,
  input  logic        ev_ready,
  output logic [4:0]  ev_target,
  output logic [15:0] ev_value,
  output logic        ev_last
);
  `include "gamepad_packet_to_input_events_macros.svh"

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PREP = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_POST = 7'b0001000,
    S_COLL = 7'b0010000,
    S_EMIT = 7'b0100000,
    S_WAIT = 7'b1000000
  } state_t;

  state_t state_r;
  logic [47:0] cal_r [4];
  logic [15:0] ldz_r, rdz_r;
  logic [14:0] fdz_r;
  logic [7:0]  lpb_r, rpb_r;
  logic [15:0] px_r [4];
  logic [1:0]  hx_r, hy_r;

  pkt_t pkt_r;
  logic axis_r;          // 0 X, 1 Y
  logic [15:0] ax_r [2];
  // Divider: quotient of num/den, restoring
  logic [33:0] num_r;
  logic [17:0] den_r;
  logic [17:0] rem_r;
  logic [5:0]  cnt_r;
  logic        neg_r, zero_r, sat_r;
  // Event list
  logic [4:0]  tgt_r [10];
  logic [15:0] val_r [10];
  logic [3:0]  n_r, e_r;

  // Per-axis setup
  logic [47:0] cal;
  logic [15:0] raw;
  logic signed [17:0] c, r, zr;
  logic [16:0] ac, ar;
  logic neg;
  always_comb begin
    cal = cal_r[{pkt_r.side, axis_r}];
    raw = axis_r ? pkt_r.y_raw : pkt_r.x_raw;
    zr  = 18'(cal[47:32]);
    c   = 18'(raw) - zr;
    r   = c[17] ? (zr - 18'(cal[15:0])) : (18'(cal[31:16]) - zr);
    ac  = c[17] ? 17'(-c) : 17'(c);
    ar  = r[17] ? 17'(-r) : 17'(r);
    neg = (c != '0) && (c[17] != r[17]);
  end

  // Divide step
  logic [18:0] trial;
  assign trial = {rem_r, num_r[33]} - {1'b0, den_r};

  // Finish axis: magnitude to value
  logic [16:0] mag;
  logic signed [17:0] v, av;
  logic [15:0] dz;
  logic [15:0] axv;
  always_comb begin
    mag = sat_r ? (neg_r ? 17'd32768 : 17'd32767) : num_r[16:0];
    v   = neg_r ? 18'(mag) : -18'(mag);
    av  = v[17] ? -v : v;
    dz  = pkt_r.side ? rdz_r : ldz_r;
    if (dz == '0) dz = 16'(fdz_r);
    if (dz > 16'd32767) dz = 16'd32767;
    if (zero_r || av < 18'(dz)) axv = '0;
    else if (v > 18'sd32767) axv = 16'd32767;
    else axv = v[15:0];
  end

  // Button and hat differences
  logic [7:0] bprev, bnew;
  logic [1:0] hx, hy;
  assign bnew  = pkt_r.button_bits;
  assign bprev = pkt_r.side ? rpb_r : lpb_r;
  always_comb begin
    hx = bnew[3] ? 2'b11 : (bnew[4] ? 2'b01 : 2'b00);
    hy = bnew[2] ? 2'b11 : (bnew[5] ? 2'b01 : 2'b00);
  end

  assign q_ready   = (state_r == S_IDLE);
  assign ev_valid  = (state_r == S_EMIT);
  assign ev_target = tgt_r[e_r];
  assign ev_value  = val_r[e_r];
  assign ev_last   = (e_r + 4'd1 == n_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int i = 0; i < 4; i++) begin
        cal_r[i] <= CAL_RESET;
        px_r[i]  <= '0;
      end
      ldz_r <= '0; rdz_r <= '0; fdz_r <= 15'd4096;
      lpb_r <= '0; rpb_r <= '0; hx_r <= '0; hy_r <= '0;
      n_r <= '0; e_r <= '0; axis_r <= 1'b0; cnt_r <= '0;
    end else begin
      // Hold configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_LX, REG_LY, REG_RX, REG_RY: cal_r[cfg_index[1:0]] <= cfg_data;
          REG_LDZ: ldz_r <= cfg_data[15:0];
          REG_RDZ: rdz_r <= cfg_data[15:0];
          REG_FDZ: fdz_r <= cfg_data[14:0];
          default: ;
        endcase
      end
      unique case (state_r)
        S_IDLE: if (q_valid) begin
          pkt_r <= q_pkt; axis_r <= 1'b0; state_r <= S_PREP;
        end
        S_PREP: begin
          neg_r  <= neg;
          zero_r <= (r == '0);
          sat_r  <= (ac >= ar);
          // numerator 2*ac*scale + ar built by shift-add
          num_r  <= 34'((({17'd0, ac} << 15) - (neg ? 34'd0 : 34'(ac))) << 1) + 34'(ar);
          den_r  <= {ar, 1'b0};
          rem_r  <= '0; cnt_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (!trial[18]) begin
            rem_r <= trial[17:0]; num_r <= {num_r[32:0], 1'b1};
          end else begin
            rem_r <= {rem_r[16:0], num_r[33]}; num_r <= {num_r[32:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd33) state_r <= S_POST;
        end
        S_POST: begin
          ax_r[axis_r] <= axv;
          if (axis_r) state_r <= S_COLL;
          else begin axis_r <= 1'b1; state_r <= S_PREP; end
        end
        S_COLL: begin
          automatic logic [3:0] n = '0;
          automatic logic [1:0] bi = {pkt_r.side, 1'b0};
          if (ax_r[0] != px_r[bi]) begin
            tgt_r[n] <= 5'(bi); val_r[n] <= ax_r[0]; n = n + 4'd1;
          end
          if (ax_r[1] != px_r[bi | 2'd1]) begin
            tgt_r[n] <= 5'(bi | 2'd1); val_r[n] <= ax_r[1]; n = n + 4'd1;
          end
          px_r[bi] <= ax_r[0]; px_r[bi | 2'd1] <= ax_r[1];
          if (pkt_r.side) begin
            for (int k = 0; k < 8; k++)
              if (bprev[right_bit(3'(k))] != bnew[right_bit(3'(k))]) begin
                tgt_r[n] <= right_target(right_bit(3'(k)));
                val_r[n] <= 16'(bnew[right_bit(3'(k))]);
                n = n + 4'd1;
              end
            rpb_r <= bnew;
          end else begin
            if (bprev[0] != bnew[0]) begin
              tgt_r[n] <= 5'd10; val_r[n] <= 16'(bnew[0]); n = n + 4'd1;
            end
            if (bprev[1] != bnew[1]) begin
              tgt_r[n] <= 5'd12; val_r[n] <= 16'(bnew[1]); n = n + 4'd1;
            end
            if (bprev[7] != bnew[7]) begin
              tgt_r[n] <= 5'd16; val_r[n] <= 16'(bnew[7]); n = n + 4'd1;
            end
            if (hx != hx_r) begin
              tgt_r[n] <= 5'd4; val_r[n] <= {{14{hx[1]}}, hx}; n = n + 4'd1;
            end
            if (hy != hy_r) begin
              tgt_r[n] <= 5'd5; val_r[n] <= {{14{hy[1]}}, hy}; n = n + 4'd1;
            end
            lpb_r <= bnew; hx_r <= hx; hy_r <= hy;
          end
          n_r <= n; e_r <= '0;
          state_r <= (n == '0) ? S_IDLE : S_EMIT;
        end
        S_EMIT: if (ev_ready) begin
          if (ev_last) state_r <= S_IDLE;
          else e_r <= e_r + 4'd1;
        end
        S_WAIT: state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `GP_ASSERT_IMP(a_emit_n, state_r == S_EMIT, e_r < n_r, "event index past count")
  `GP_ASSERT_IMP(a_n_max, 1'b1, n_r <= 4'd10, "too many events")
  `GP_ASSERT_NEXT(a_last_idle, ev_valid && ev_ready && ev_last, state_r == S_IDLE,
    "did not return after last event")
endmodule
